// ----- sv/hsl_pkg.sv -----
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared types and codes for the bounded sorted hit list: record layout,
// request and status codes, controller states and list sizing.
// ----------------------------------------------------------------------------
package hsl_pkg;

  // list depth and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;

  // request codes (code 3 is unused)
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_READ   = 2'd2
  } req_code_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DROPPED   = 3'd1,
    STAT_READ_OK   = 3'd2,
    STAT_READ_OOR  = 3'd3,
    STAT_CLEARED   = 3'd4
  } status_code_t;

  // one stored hit record
  typedef struct packed {
    logic [31:0] hit_dist;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [15:0] obj;
    logic [23:0] face;
    logic        facing;
  } hit_rec_t;

  // controller states: result register empty or holding a word
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_HOLD = 1'b1
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic step;   // take the request word and update list and result
  } hsl_cmd_t;

endpackage

// ----- sv/bounded_sorted_hit_list.sv -----
// ----------------------------------------------------------------------------
// bounded_sorted_hit_list
// Keeps up to CAPACITY ray-hit records sorted by ascending distance; insert,
// clear and read requests each return one result word.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------------
//  request | req_valid / req_ready | req_type, hit record fields, read_index
//  result  | rsp_valid / rsp_ready | status, entry_count, out_* record fields
//
//  One request word per cycle while results are taken; its result is registered
//  and shows up on the cycle after acceptance. All cells compare against the
//  new key in parallel and shift together.
//  Reset empties the list (fill count only) and the result slot.
//  A stalled result blocks a new request unless it is taken in that cycle.
// ----------------------------------------------------------------------------
module bounded_sorted_hit_list
  import hsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         req_type,
  input  logic [31:0]        hit_distance,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] normal_x,
  input  logic signed [31:0] normal_y,
  input  logic signed [31:0] normal_z,
  input  logic [15:0]        object_id,
  input  logic [23:0]        face_index,
  input  logic               front_facing,
  input  logic [5:0]         read_index,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [2:0]         status,
  output logic [6:0]         entry_count,
  output logic [31:0]        out_distance,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic signed [31:0] out_normal_x,
  output logic signed [31:0] out_normal_y,
  output logic signed [31:0] out_normal_z,
  output logic [15:0]        out_object_id,
  output logic [23:0]        out_face_index,
  output logic               out_front_facing
);

  hsl_cmd_t         cmd;
  hit_rec_t         new_rec;
  hit_rec_t         res_rec;
  logic [CNT_W-1:0] res_count;

  // incoming record
  always_comb begin
    new_rec.hit_dist = hit_distance;
    new_rec.px       = point_x;
    new_rec.py       = point_y;
    new_rec.pz       = point_z;
    new_rec.nx       = normal_x;
    new_rec.ny       = normal_y;
    new_rec.nz       = normal_z;
    new_rec.obj      = object_id;
    new_rec.face     = face_index;
    new_rec.facing   = front_facing;
  end

  hsl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  hsl_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_type   (req_type),
    .new_rec    (new_rec),
    .read_index (read_index),
    .res_status (status),
    .res_count  (res_count),
    .res_rec    (res_rec)
  );

  // result fields
  assign entry_count      = res_count;
  assign out_distance     = res_rec.hit_dist;
  assign out_point_x      = res_rec.px;
  assign out_point_y      = res_rec.py;
  assign out_point_z      = res_rec.pz;
  assign out_normal_x     = res_rec.nx;
  assign out_normal_y     = res_rec.ny;
  assign out_normal_z     = res_rec.nz;
  assign out_object_id    = res_rec.obj;
  assign out_face_index   = res_rec.face;
  assign out_front_facing = res_rec.facing;

  // an accepted request always yields a result word next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("accepted request produced no result");

  // count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // a clear leaves an empty list
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STAT_CLEARED |-> entry_count == '0)
    else $error("clear left records");

  // only a valid read carries record data
  a_no_stray_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STAT_READ_OK |-> out_distance == '0 && out_object_id == '0)
    else $error("record data on a non-read result");

endmodule

// ----- sv/hsl_ctrl.sv -----
// ----------------------------------------------------------------------------
// hsl_ctrl
// Handshake controller: tracks whether the result register holds a word and
// tells the datapath when to take a request.
// ----------------------------------------------------------------------------
module hsl_ctrl
  import hsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output hsl_cmd_t cmd
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (req_valid) state_next = CS_HOLD;
      end
      CS_HOLD: begin
        if (rsp_ready && !req_valid) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // outputs: a new word may enter when the result slot is empty or draining
  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      CS_IDLE: begin
        req_ready = 1'b1;
      end
      CS_HOLD: begin
        rsp_valid = 1'b1;
        req_ready = rsp_ready;
      end
      default: begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
      end
    endcase
    cmd.step = req_valid && req_ready;
  end

endmodule

// ----- sv/hsl_datapath.sv -----
// ----------------------------------------------------------------------------
// hsl_datapath
// Row of compare-and-shift cells holding the sorted records, the fill count
// and the registered result word.
// ----------------------------------------------------------------------------
module hsl_datapath
  import hsl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  hsl_cmd_t           cmd,
  input  logic [1:0]         req_type,
  input  hit_rec_t           new_rec,
  input  logic [5:0]         read_index,
  output logic [2:0]         res_status,
  output logic [CNT_W-1:0]   res_count,
  output hit_rec_t           res_rec
);

  hit_rec_t             cells [CAPACITY];
  logic [CAPACITY-1:0]  le;
  logic [CNT_W-1:0]     fill_count;
  logic                 full;
  logic                 drop;
  logic                 do_shift;
  logic                 read_hit;
  logic [2:0]           status_next;
  logic [CNT_W-1:0]     count_next;
  hit_rec_t             rec_next;

  // per-cell compare: stored and at or below the new key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (CNT_W'(i) < fill_count) && (cells[i].hit_dist <= new_rec.hit_dist);
    end
  end

  assign full     = (fill_count >= CNT_W'(CAPACITY));
  assign drop     = full && le[CAPACITY-1];
  assign do_shift = cmd.step && (req_type == REQ_INSERT) && !drop;

  // cells: keep, load the new record, or take the neighbor's record
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_shift && !le[g]) begin
        if (g == 0) begin
          cells[g] <= new_rec;
        end else if (le[(g > 0) ? g - 1 : 0]) begin
          cells[g] <= new_rec;
        end else begin
          cells[g] <= cells[(g > 0) ? g - 1 : 0];
        end
      end
    end
  end

  // read bounds check
  assign read_hit = (CNT_W'(read_index) < fill_count) &&
                    (CNT_W'(read_index) < CNT_W'(CAPACITY));

  // result word and new count
  always_comb begin
    status_next = STAT_DROPPED;
    count_next  = fill_count;
    rec_next    = '0;
    case (req_type)
      REQ_INSERT: begin
        if (drop) begin
          status_next = STAT_DROPPED;
        end else begin
          status_next = STAT_INSERTED;
          if (!full) count_next = fill_count + CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        status_next = STAT_CLEARED;
        count_next  = '0;
      end
      REQ_READ: begin
        if (read_hit) begin
          status_next = STAT_READ_OK;
          rec_next    = cells[read_index[IDX_W-1:0]];
        end else begin
          status_next = STAT_READ_OOR;
        end
      end
      default: status_next = STAT_DROPPED;
    endcase
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.step) begin
      fill_count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      res_status <= status_next;
      res_count  <= count_next;
      res_rec    <= rec_next;
    end
  end

endmodule

// ----- bench/bounded_sorted_hit_list_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_sorted_hit_list_tb
// Self-checking bench for the sorted hit list. A scoreboard keeps its own
// copy of the sorted records and predicts every result word. Request words
// go out in bursts with random gaps while the result side stalls on its own
// pattern. A directed run covers the edges of the list, then a long random
// run of inserts, reads and clears follows.
// ----------------------------------------------------------------------------
module bounded_sorted_hit_list_tb;
  import hsl_pkg::*;

  // request code that the block does not define
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1200;
  localparam int MAX_REPORTS  = 200;

  // one result word as seen on the result port
  typedef struct packed {
    logic [2:0] status;
    logic [6:0] count;
    hit_rec_t   rec;
  } hit_result_t;

  // sorted list predictor plus queue of pending results
  class hit_list_scoreboard;
    hit_rec_t    records [CAPACITY];
    int unsigned fill = 0;
    hit_result_t pending_results [$];
    int          errors = 0;

    // update the list copy with an accepted request word and queue its result
    function void note_request(logic [1:0] kind, hit_rec_t rec, logic [5:0] idx);
      hit_result_t want;
      int unsigned pos;
      int unsigned last;
      want = '0;
      if (kind == REQ_INSERT) begin
        pos = 0;
        while (pos < fill && records[pos].hit_dist <= rec.hit_dist)
          pos++;
        if (pos >= CAPACITY) begin
          want.status = STAT_DROPPED;
        end else begin
          // a full list loses its last record
          last = (fill < CAPACITY) ? fill : CAPACITY - 1;
          for (int unsigned i = last; i > pos; i--)
            records[i] = records[i - 1];
          records[pos] = rec;
          if (fill < CAPACITY)
            fill++;
          want.status = STAT_INSERTED;
        end
      end else if (kind == REQ_CLEAR) begin
        fill = 0;
        want.status = STAT_CLEARED;
      end else if (kind == REQ_READ) begin
        if (idx < fill) begin
          want.status = STAT_READ_OK;
          want.rec    = records[idx];
        end else begin
          want.status = STAT_READ_OOR;
        end
      end else begin
        want.status = STAT_DROPPED;
      end
      want.count = fill[6:0];
      pending_results.push_back(want);
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, seen);
      end
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_result(hit_result_t seen);
      hit_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result word with nothing pending, expected none, got status %0d",
                   $time, seen.status);
        return;
      end
      want = pending_results.pop_front();
      compare_field("status",       want.status,       seen.status);
      compare_field("entry_count",  want.count,        seen.count);
      compare_field("out_distance", want.rec.hit_dist, seen.rec.hit_dist);
      compare_field("out_point_x",  want.rec.px,       seen.rec.px);
      compare_field("out_point_y",  want.rec.py,       seen.rec.py);
      compare_field("out_point_z",  want.rec.pz,       seen.rec.pz);
      compare_field("out_normal_x", want.rec.nx,       seen.rec.nx);
      compare_field("out_normal_y", want.rec.ny,       seen.rec.ny);
      compare_field("out_normal_z", want.rec.nz,       seen.rec.nz);
      compare_field("out_object_id", want.rec.obj,   seen.rec.obj);
      compare_field("out_face_index", want.rec.face, seen.rec.face);
      compare_field("out_front_facing", want.rec.facing, seen.rec.facing);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [1:0]         req_type = REQ_INSERT;
  logic [31:0]        hit_distance = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic signed [31:0] normal_x = '0;
  logic signed [31:0] normal_y = '0;
  logic signed [31:0] normal_z = '0;
  logic [15:0]        object_id = '0;
  logic [23:0]        face_index = '0;
  logic               front_facing = 1'b0;
  logic [5:0]         read_index = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic [2:0]         status;
  logic [6:0]         entry_count;
  logic [31:0]        out_distance;
  logic signed [31:0] out_point_x;
  logic signed [31:0] out_point_y;
  logic signed [31:0] out_point_z;
  logic signed [31:0] out_normal_x;
  logic signed [31:0] out_normal_y;
  logic signed [31:0] out_normal_z;
  logic [15:0]        out_object_id;
  logic [23:0]        out_face_index;
  logic               out_front_facing;

  hit_list_scoreboard sb = new;
  hit_rec_t           sent_rec;
  hit_result_t        seen_result;
  int                 ready_mode = 0;
  int                 ready_left = 0;

  bounded_sorted_hit_list DUT (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .req_type         (req_type),
    .hit_distance     (hit_distance),
    .point_x          (point_x),
    .point_y          (point_y),
    .point_z          (point_z),
    .normal_x         (normal_x),
    .normal_y         (normal_y),
    .normal_z         (normal_z),
    .object_id        (object_id),
    .face_index       (face_index),
    .front_facing     (front_facing),
    .read_index       (read_index),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .status           (status),
    .entry_count      (entry_count),
    .out_distance     (out_distance),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_object_id    (out_object_id),
    .out_face_index   (out_face_index),
    .out_front_facing (out_front_facing)
  );

  always #5 clk = ~clk;

  // result side: stall pattern switches between always ready, coin flip and
  // mostly stalled, each held for a random stretch
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(8, 80);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0, 1: rsp_ready <= 1'b1;
      2: rsp_ready <= $urandom_range(0, 1);
      default: rsp_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: note accepted requests, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        seen_result.status       = status;
        seen_result.count        = entry_count;
        seen_result.rec.hit_dist = out_distance;
        seen_result.rec.px       = out_point_x;
        seen_result.rec.py       = out_point_y;
        seen_result.rec.pz       = out_point_z;
        seen_result.rec.nx       = out_normal_x;
        seen_result.rec.ny       = out_normal_y;
        seen_result.rec.nz       = out_normal_z;
        seen_result.rec.obj      = out_object_id;
        seen_result.rec.face     = out_face_index;
        seen_result.rec.facing   = out_front_facing;
        sb.check_result(seen_result);
      end
      if (req_valid && req_ready) begin
        sent_rec.hit_dist = hit_distance;
        sent_rec.px       = point_x;
        sent_rec.py       = point_y;
        sent_rec.pz       = point_z;
        sent_rec.nx       = normal_x;
        sent_rec.ny       = normal_y;
        sent_rec.nz       = normal_z;
        sent_rec.obj      = object_id;
        sent_rec.face     = face_index;
        sent_rec.facing   = front_facing;
        sb.note_request(req_type, sent_rec, read_index);
      end
    end
  end

  // present one request word and wait until it is taken
  task automatic send_word(input logic [1:0] kind, input hit_rec_t rec,
                           input logic [5:0] idx);
    @(negedge clk);
    req_valid    <= 1'b1;
    req_type     <= kind;
    hit_distance <= rec.hit_dist;
    point_x      <= rec.px;
    point_y      <= rec.py;
    point_z      <= rec.pz;
    normal_x     <= rec.nx;
    normal_y     <= rec.ny;
    normal_z     <= rec.nz;
    object_id    <= rec.obj;
    face_index   <= rec.face;
    front_facing <= rec.facing;
    read_index   <= idx;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // random record; distances lean toward ties and extremes
  function automatic hit_rec_t random_hit();
    hit_rec_t rec;
    rec.px     = $urandom;
    rec.py     = $urandom;
    rec.pz     = $urandom;
    rec.nx     = $urandom;
    rec.ny     = $urandom;
    rec.nz     = $urandom;
    rec.obj    = $urandom;
    rec.face   = $urandom;
    rec.facing = $urandom;
    case ($urandom_range(0, 9))
      0: rec.hit_dist = 32'h0000_0000;
      1: rec.hit_dist = 32'hFFFF_FFFF;
      2, 3, 4, 5: rec.hit_dist = $urandom_range(0, 40);
      default: rec.hit_dist = $urandom;
    endcase
    return rec;
  endfunction

  // stimulus
  initial begin
    hit_rec_t   rec_hi;
    hit_rec_t   rec_lo;
    hit_rec_t   rec;
    logic [1:0] kind;
    logic [5:0] idx;
    int         sent;
    int         burst;
    int         pick;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, unused code, extreme records, ties, full list
    rec_hi = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               16'hFFFF, 24'hFF_FFFF, 1'b1};
    rec_lo = '{32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               16'h0000, 24'h00_0000, 1'b0};
    send_word(REQ_READ, rec_hi, 6'd63);
    send_word(REQ_UNUSED, rec_hi, 6'd0);
    send_word(REQ_INSERT, rec_hi, 6'd63);
    send_word(REQ_INSERT, rec_lo, 6'd0);
    // equal key lands behind the stored one
    rec = random_hit();
    rec.hit_dist = 32'h0;
    send_word(REQ_INSERT, rec, 6'd0);
    send_word(REQ_READ, rec_lo, 6'd0);
    send_word(REQ_READ, rec_lo, 6'd1);
    for (int i = 0; i < CAPACITY - 3; i++) begin
      rec = random_hit();
      rec.hit_dist = (i + 1) << 16;
      send_word(REQ_INSERT, rec, 6'($urandom));
    end
    // full list: key past the end is dropped, a small key pushes out the last
    send_word(REQ_INSERT, rec_hi, 6'd0);
    rec = random_hit();
    rec.hit_dist = 32'h1;
    send_word(REQ_INSERT, rec, 6'd0);
    send_word(REQ_READ, rec_lo, 6'(CAPACITY - 1));
    send_word(REQ_READ, rec_lo, 6'(CAPACITY));
    send_word(REQ_CLEAR, rec_lo, 6'd0);

    // random bursts of mostly inserts and reads with occasional clears
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)      kind = REQ_INSERT;
        else if (pick < 90) kind = REQ_READ;
        else if (pick < 97) kind = REQ_CLEAR;
        else                kind = REQ_UNUSED;
        idx = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, CAPACITY - 1))
                                          : 6'($urandom_range(0, 63));
        send_word(kind, random_hit(), idx);
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        idle_cycles($urandom_range(1, 6));
    end
    @(negedge clk);
    req_valid <= 1'b0;

    // drain, then let the bench run quiet before the verdict
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
